// ===== hw/rtl/dmoc_pkg.sv =====
// Shared constants, types and helper functions of the diamond open/close filter.
package dmoc_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_RADIUS   = 8;
    localparam int PIXEL_BITS   = 8;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int RAM_DEPTH  = RING_ROWS * MAX_WIDTH;
    localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS   = $clog2(HEIGHT_LIMIT);
    localparam int SLOT_BITS  = (RING_ROWS > 1) ? $clog2(RING_ROWS) : 1;
    localparam int NUM_BITS   = $clog2(RING_ROWS + 1);
    localparam int RAD_BITS   = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int ADDR_BITS  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int WARM_BITS  = $clog2(2 * MAX_RADIUS * MAX_WIDTH + 2);

    // Register fields as seen on the configuration port
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int CFG_RADIUS_BITS = 4;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 13;

    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_RADIUS       = 3'd2,
        CFG_OPEN_MODE    = 3'd3
    } t_cfg_idx;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [COL_BITS:0]     w;
        logic [ROW_BITS:0]     h;
        logic [RAD_BITS-1:0]   r;
        logic                  open_mode;
    } t_cfg;

    // One classified pixel handed from the front to the back
    typedef struct packed {
        logic [PIXEL_BITS-1:0] px;
        logic [SLOT_BITS-1:0]  cur;
        logic [COL_BITS-1:0]   in_col;
        logic                  run1;
        logic [SLOT_BITS-1:0]  s1;
        logic [SLOT_BITS-1:0]  s2;
        logic [ROW_BITS-1:0]   row1;
        logic [COL_BITS-1:0]   col1;
        logic                  run2;
        logic [SLOT_BITS-1:0]  t2;
        logic [ROW_BITS-1:0]   row2;
        logic [COL_BITS-1:0]   col2;
        logic                  eof;
    } t_cmd;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_ROW,
        SQ_COL,
        SQ_DONE
    } t_seq_state;

    typedef struct packed {
        logic [CMD_PTR_BITS:0] cmd_cnt;
    } t_front_stat;

    typedef struct packed {
        logic       seq_idle;
        logic [1:0] out_cnt;
    } t_back_stat;

    // Max or min of two pixels
    function automatic logic [PIXEL_BITS-1:0] px_pick(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b,
        input logic                  take_max
    );
        if (take_max) begin
            return (b > a) ? b : a;
        end
        return (b < a) ? b : a;
    endfunction

    // Ring slot r rows back, modulo n
    function automatic logic [SLOT_BITS-1:0] slot_back(
        input logic [SLOT_BITS-1:0] slot,
        input logic [RAD_BITS-1:0]  r,
        input logic [NUM_BITS-1:0]  n
    );
        logic [NUM_BITS:0] sum;
        sum = (NUM_BITS + 1)'(slot) + (NUM_BITS + 1)'(n) - (NUM_BITS + 1)'(r);
        if ((NUM_BITS + 1)'(slot) >= (NUM_BITS + 1)'(r)) begin
            return SLOT_BITS'((NUM_BITS + 1)'(slot) - (NUM_BITS + 1)'(r));
        end
        return SLOT_BITS'(sum);
    endfunction

endpackage

// ===== hw/rtl/dmoc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dmoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dmoc_front.sv =====
// Front end: configuration registers, raster position tracking and command queue.
module dmoc_front import dmoc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [PIXEL_BITS-1:0]    i_pixel_in,
    output logic                     o_full,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg,
    output t_cmd                     o_cmd,
    output logic                     o_cmd_valid,
    input  logic                     i_cmd_pop,
    output t_front_stat              o_stat
);

    logic [CFG_WIDTH_BITS-1:0]  r_image_width;
    logic [CFG_HEIGHT_BITS-1:0] r_image_height;
    logic [CFG_RADIUS_BITS-1:0] r_radius;
    logic                       r_open_mode;

    logic [COL_BITS-1:0]  r_in_col, n_in_col, r_col1, n_col1, r_col2, n_col2;
    logic [ROW_BITS-1:0]  r_in_row, n_in_row, r_row1, n_row1, r_row2, n_row2;
    logic [SLOT_BITS-1:0] r_slot, n_slot;
    logic [WARM_BITS-1:0] r_warm, n_warm;

    t_cmd                  r_q [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] r_wp, r_rp;
    logic [CMD_PTR_BITS:0]   r_cnt;

    t_cfg                  cfg;
    t_cmd                  cmd;
    logic [NUM_BITS-1:0]   n_ring;
    logic [WARM_BITS-1:0]  rw, rw2;
    logic                  accept, pop, cfg_hit;
    logic [ROW_BITS+COL_BITS-1:0] adv_in, adv1, adv2;

    // Step a raster position by one pixel
    function automatic logic [ROW_BITS+COL_BITS-1:0] adv(
        input logic [COL_BITS-1:0] col,
        input logic [ROW_BITS-1:0] row,
        input logic [COL_BITS:0]   w,
        input logic [ROW_BITS:0]   h
    );
        logic [COL_BITS:0] c1;
        logic [ROW_BITS:0] r1;
        c1 = {1'b0, col} + 1'b1;
        r1 = {1'b0, row} + 1'b1;
        if (c1 >= w) begin
            if (r1 >= h) begin
                return '0;
            end
            return {r1[ROW_BITS-1:0], {COL_BITS{1'b0}}};
        end
        return {row, c1[COL_BITS-1:0]};
    endfunction

    // Configuration writes; any known register restarts the stream
    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid && ((i_cfg_index == CFG_IMAGE_WIDTH)
                  || (i_cfg_index == CFG_IMAGE_HEIGHT) || (i_cfg_index == CFG_RADIUS)
                  || (i_cfg_index == CFG_OPEN_MODE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_WIDTH_BITS'(1024);
            r_image_height <= CFG_HEIGHT_BITS'(512);
            r_radius       <= CFG_RADIUS_BITS'(1);
            r_open_mode    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[CFG_WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[CFG_HEIGHT_BITS-1:0];
                CFG_RADIUS:       r_radius       <= i_cfg_data[CFG_RADIUS_BITS-1:0];
                CFG_OPEN_MODE:    r_open_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp registers to their usable ranges
    always_comb begin
        if (r_image_width == '0) begin
            cfg.w = (COL_BITS + 1)'(1);
        end else if (r_image_width > MAX_WIDTH) begin
            cfg.w = (COL_BITS + 1)'(MAX_WIDTH);
        end else begin
            cfg.w = (COL_BITS + 1)'(r_image_width);
        end
        if (r_image_height == '0) begin
            cfg.h = (ROW_BITS + 1)'(1);
        end else if (r_image_height > HEIGHT_LIMIT) begin
            cfg.h = (ROW_BITS + 1)'(HEIGHT_LIMIT);
        end else begin
            cfg.h = (ROW_BITS + 1)'(r_image_height);
        end
        if (r_radius > MAX_RADIUS) begin
            cfg.r = RAD_BITS'(MAX_RADIUS);
        end else begin
            cfg.r = RAD_BITS'(r_radius);
        end
        cfg.open_mode = r_open_mode;
    end

    assign o_cfg  = cfg;
    assign n_ring = NUM_BITS'(2 * cfg.r + 1);
    assign rw     = WARM_BITS'(cfg.r) * WARM_BITS'(cfg.w);
    assign rw2    = rw << 1;

    // Classify the incoming word: stage positions, ring slots, warm-up flags
    always_comb begin
        cmd.px     = i_pixel_in;
        cmd.cur    = r_slot;
        cmd.in_col = r_in_col;
        cmd.run1   = (r_warm >= rw);
        cmd.run2   = (r_warm >= rw2);
        cmd.s1     = slot_back(r_slot, cfg.r, n_ring);
        cmd.s2     = slot_back(cmd.s1, cfg.r, n_ring);
        cmd.t2     = slot_back(cmd.s2, cfg.r, n_ring);
        cmd.row1   = r_row1;
        cmd.col1   = r_col1;
        cmd.row2   = r_row2;
        cmd.col2   = r_col2;
        cmd.eof    = cmd.run2 && ({1'b0, r_col2} == cfg.w - 1'b1)
                  && ({1'b0, r_row2} == cfg.h - 1'b1);
    end

    assign accept = i_push && !o_full;
    assign pop    = i_cmd_pop && (r_cnt != '0);

    // Advance positions on each accepted word
    always_comb begin
        adv_in   = adv(r_in_col, r_in_row, cfg.w, cfg.h);
        adv1     = adv(r_col1, r_row1, cfg.w, cfg.h);
        adv2     = adv(r_col2, r_row2, cfg.w, cfg.h);
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_col1   = r_col1;
        n_row1   = r_row1;
        n_col2   = r_col2;
        n_row2   = r_row2;
        n_slot   = r_slot;
        n_warm   = r_warm;
        if (accept) begin
            {n_in_row, n_in_col} = adv_in;
            if (adv_in[COL_BITS-1:0] == '0) begin
                n_slot = ((NUM_BITS'(r_slot) + NUM_BITS'(1)) == n_ring) ? '0
                       : r_slot + 1'b1;
            end
            if (cmd.run1) begin
                {n_row1, n_col1} = adv1;
            end
            if (cmd.run2) begin
                {n_row2, n_col2} = adv2;
            end
            if (r_warm < rw2) begin
                n_warm = r_warm + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_col1   <= '0;
            r_row1   <= '0;
            r_col2   <= '0;
            r_row2   <= '0;
            r_slot   <= '0;
            r_warm   <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_col1   <= n_col1;
            r_row1   <= n_row1;
            r_col2   <= n_col2;
            r_row2   <= n_row2;
            r_slot   <= n_slot;
            r_warm   <= n_warm;
        end
    end

    // Command queue toward the back end
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (CMD_PTR_BITS + 1)'(accept) - (CMD_PTR_BITS + 1)'(pop);
        end
    end

    assign o_full         = (r_cnt == (CMD_PTR_BITS + 1)'(CMD_DEPTH));
    assign o_cmd          = r_q[r_rp];
    assign o_cmd_valid    = (r_cnt != '0);
    assign o_stat.cmd_cnt = r_cnt;

endmodule

// ===== hw/rtl/dmoc_back.sv =====
// Back end: diamond sequencer over both row stores and the result queue.
module dmoc_back import dmoc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_cmd                  i_cmd,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_pop,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic                  o_end_of_frame,
    output t_back_stat            o_stat
);

    t_seq_state            r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic                  r_stage, n_stage;
    logic [SLOT_BITS-1:0]  r_k, n_k, r_slot, n_slot;
    logic [COL_BITS-1:0]   r_col, n_col, r_hi, n_hi;
    logic [PIXEL_BITS-1:0] r_acc, n_acc, r_mid, n_mid;
    logic                  r_pend, n_pend;

    logic [PIXEL_BITS-1:0] r_oq_px [2];
    logic                  r_oq_eof [2];
    logic                  r_oq_wp, r_oq_rp;
    logic [1:0]            r_oq_cnt;

    logic                  in_we, mid_we, push_out, pop_out;
    logic [ADDR_BITS-1:0]  in_waddr, mid_waddr, rd_addr;
    logic [PIXEL_BITS-1:0] in_rdata, mid_rdata, rd_data;

    logic [ROW_BITS-1:0]        cen_row;
    logic [COL_BITS-1:0]        cen_col;
    logic                       take_max, row_ok, tip_ok;
    logic [NUM_BITS-1:0]        n_ring;
    logic [SLOT_BITS-1:0]       two_r, slot_inc;
    logic signed [ROW_BITS+1:0] rr;
    logic signed [SLOT_BITS:0]  dk;
    logic [SLOT_BITS:0]         abs_dk;
    logic [RAD_BITS-1:0]        half;
    logic signed [COL_BITS+1:0] lo_s;
    logic [COL_BITS:0]          hi_u;
    logic [COL_BITS-1:0]        lo, hi;
    logic [ROW_BITS+1:0]        tip_row;
    logic [PIXEL_BITS-1:0]      acc_now, tip, final_val, init0, init2;

    // Row stores
    dmoc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RAM_DEPTH)) u_in_rows (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (in_waddr),
        .i_wdata (i_cmd.px),
        .i_raddr (rd_addr),
        .o_rdata (in_rdata)
    );

    dmoc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RAM_DEPTH)) u_mid_rows (
        .i_clk   (i_clk),
        .i_we    (mid_we),
        .i_waddr (mid_waddr),
        .i_wdata (final_val),
        .i_raddr (rd_addr),
        .o_rdata (mid_rdata)
    );

    // Stage view: center, extreme direction, tip and fold of the last read
    always_comb begin
        cen_row  = r_stage ? r_cmd.row2 : r_cmd.row1;
        cen_col  = r_stage ? r_cmd.col2 : r_cmd.col1;
        take_max = r_stage ? i_cfg.open_mode : !i_cfg.open_mode;
        tip      = r_stage ? r_mid : r_cmd.px;
        rd_data  = r_stage ? mid_rdata : in_rdata;
        acc_now  = r_pend ? px_pick(r_acc, rd_data, take_max) : r_acc;
        init0    = i_cfg.open_mode ? '1 : '0;
        init2    = i_cfg.open_mode ? '0 : '1;
        n_ring   = NUM_BITS'(2 * i_cfg.r + 1);
        two_r    = SLOT_BITS'(2 * i_cfg.r);
        slot_inc = ((NUM_BITS'(r_slot) + NUM_BITS'(1)) == n_ring) ? '0 : r_slot + 1'b1;

        tip_row   = (ROW_BITS + 2)'(cen_row) + (ROW_BITS + 2)'(i_cfg.r);
        tip_ok    = tip_row < (ROW_BITS + 2)'(i_cfg.h);
        final_val = tip_ok ? px_pick(acc_now, tip, take_max) : acc_now;

        // Current diamond row and its clipped column span
        rr = $signed((ROW_BITS + 2)'(cen_row)) + $signed((ROW_BITS + 2)'(r_k))
           - $signed((ROW_BITS + 2)'(i_cfg.r));
        row_ok = !rr[ROW_BITS+1] && (rr < $signed((ROW_BITS + 2)'(i_cfg.h)));
        dk     = $signed((SLOT_BITS + 1)'(r_k)) - $signed((SLOT_BITS + 1)'(i_cfg.r));
        abs_dk = dk[SLOT_BITS] ? (SLOT_BITS + 1)'(-dk) : (SLOT_BITS + 1)'(dk);
        half   = i_cfg.r - RAD_BITS'(abs_dk);
        lo_s   = $signed((COL_BITS + 2)'(cen_col)) - $signed((COL_BITS + 2)'(half));
        lo     = lo_s[COL_BITS+1] ? '0 : lo_s[COL_BITS-1:0];
        hi_u   = (COL_BITS + 1)'(cen_col) + (COL_BITS + 1)'(half);
        hi     = (hi_u >= i_cfg.w) ? COL_BITS'(i_cfg.w - 1'b1) : hi_u[COL_BITS-1:0];

        rd_addr   = ADDR_BITS'(r_slot) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(r_col);
        in_waddr  = ADDR_BITS'(i_cmd.cur) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(i_cmd.in_col);
        mid_waddr = ADDR_BITS'(r_cmd.s1) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(r_cmd.col1);
    end

    // Sequencer: walk diamond rows, read each column, close each stage
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_stage   = r_stage;
        n_k       = r_k;
        n_slot    = r_slot;
        n_col     = r_col;
        n_hi      = r_hi;
        n_acc     = acc_now;
        n_mid     = r_mid;
        n_pend    = 1'b0;
        o_cmd_pop = 1'b0;
        in_we     = 1'b0;
        mid_we    = 1'b0;
        push_out  = 1'b0;
        unique case (r_state)
            SQ_IDLE: begin
                if (i_cmd_valid && (r_oq_cnt != 2'd2)) begin
                    o_cmd_pop = 1'b1;
                    in_we     = 1'b1;
                    n_cmd     = i_cmd;
                    n_stage   = 1'b0;
                    n_k       = '0;
                    n_slot    = i_cmd.s2;
                    n_acc     = init0;
                    n_state   = i_cmd.run1 ? SQ_ROW : SQ_IDLE;
                end
            end
            SQ_ROW: begin
                if (r_k == two_r) begin
                    n_state = SQ_DONE;
                end else if (row_ok) begin
                    n_col   = lo;
                    n_hi    = hi;
                    n_state = SQ_COL;
                end else begin
                    n_k    = r_k + 1'b1;
                    n_slot = slot_inc;
                end
            end
            SQ_COL: begin
                n_pend = 1'b1;
                if (r_col == r_hi) begin
                    n_k     = r_k + 1'b1;
                    n_slot  = slot_inc;
                    n_state = SQ_ROW;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            SQ_DONE: begin
                if (!r_stage) begin
                    mid_we = 1'b1;
                    n_mid  = final_val;
                    if (r_cmd.run2) begin
                        n_stage = 1'b1;
                        n_k     = '0;
                        n_slot  = r_cmd.t2;
                        n_acc   = init2;
                        n_state = SQ_ROW;
                    end else begin
                        n_state = SQ_IDLE;
                    end
                end else begin
                    push_out = 1'b1;
                    n_state  = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_stage <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_k    <= n_k;
        r_slot <= n_slot;
        r_col  <= n_col;
        r_hi   <= n_hi;
        r_acc  <= n_acc;
        r_mid  <= n_mid;
    end

    // Result queue: hold finished words until popped
    assign pop_out = i_pop && (r_oq_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push_out) begin
            r_oq_px[r_oq_wp]  <= final_val;
            r_oq_eof[r_oq_wp] <= r_cmd.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (push_out) begin
                r_oq_wp <= !r_oq_wp;
            end
            if (pop_out) begin
                r_oq_rp <= !r_oq_rp;
            end
            r_oq_cnt <= r_oq_cnt + 2'(push_out) - 2'(pop_out);
        end
    end

    assign o_empty         = (r_oq_cnt == 2'd0);
    assign o_pixel_out     = r_oq_px[r_oq_rp];
    assign o_end_of_frame  = r_oq_eof[r_oq_rp];
    assign o_stat.seq_idle = (r_state == SQ_IDLE);
    assign o_stat.out_cnt  = r_oq_cnt;

endmodule

// ===== hw/rtl/diamond_morphology_open_close.sv =====
// Top level of the streaming diamond opening/closing filter.
// Latency: a pixel's result leaves with the word 2*R*width words later; that
//   word's result is ready once both stages have walked their diamonds.
// The sequencer takes a new word only when idle, then walks each stage's
//   diamond over its row store one read per cycle (fewer reads at clipped edges).
// Reset: control, positions and queues clear; row stores hold unknown data.
module diamond_morphology_open_close import dmoc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [PIXEL_BITS-1:0]    i_pixel_in,
    output logic                     empty,
    input  logic                     pop,
    output logic [PIXEL_BITS-1:0]    o_pixel_out,
    output logic                     o_end_of_frame,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg        cfg;
    t_cmd        cmd;
    logic        cmd_valid, cmd_pop;
    t_front_stat front_stat;
    t_back_stat  back_stat;

    dmoc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pixel_in  (i_pixel_in),
        .o_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_stat      (front_stat)
    );

    dmoc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_pop      (cmd_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_pixel_out    (o_pixel_out),
        .o_end_of_frame (o_end_of_frame),
        .o_stat         (back_stat)
    );

    // Result queue never goes past two words
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.out_cnt != 2'd3)
        else $error("result queue overflow");

    // A busy sequencer never drains the command queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !back_stat.seq_idle |=> front_stat.cmd_cnt >= $past(front_stat.cmd_cnt))
        else $error("command popped while sequencer busy");

    // With nothing queued and the sequencer idle, no result appears
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_stat.cmd_cnt == '0 && back_stat.seq_idle && !(pop && !empty))
        |=> back_stat.out_cnt <= $past(back_stat.out_cnt))
        else $error("result produced without work");

endmodule
